[design/lagged_fibonacci_random_generator_macros.svh]
// Assertion macros used by the lagged Fibonacci generator top level.
`ifndef LAGGED_FIBONACCI_RANDOM_GENERATOR_MACROS_SVH
`define LAGGED_FIBONACCI_RANDOM_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is held.
`define LFRG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LFRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LFRG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LFRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/lfrg_pkg.sv]
// Types and constants shared by the lagged Fibonacci generator and its channel interfaces.
package lfrg_pkg;

    // Fraction width of table entries, draws and the carry sequence.
    localparam int FRAC_W = 24;

    typedef logic [1:0]        t_op;
    typedef logic [63:0]       t_seed;
    typedef logic [31:0]       t_word;
    typedef logic [FRAC_W-1:0] t_frac;

    // Operation codes.
    localparam t_op OP_SEED    = 2'd0;
    localparam t_op OP_FRAC    = 2'd1;
    localparam t_op OP_BOUNDED = 2'd2;

    // Seed reduction moduli and the seeds used after reset.
    localparam t_word       C_IJ_MOD  = 32'd31328;
    localparam t_word       C_KL_MOD  = 32'd30081;
    localparam logic [14:0] C_IJ_BOOT = 15'd1802;
    localparam logic [14:0] C_KL_BOOT = 15'd9373;

    // Constants of the seeding bit recurrence.
    localparam logic [7:0] C_IJ_DIV = 8'd177;
    localparam logic [7:0] C_KL_DIV = 8'd169;
    localparam logic [7:0] C_M_MOD  = 8'd179;
    localparam logic [7:0] C_L_MOD  = 8'd169;
    localparam logic [7:0] C_L_MUL  = 8'd53;

    // Arithmetic carry sequence.
    localparam t_frac C_CARRY_INIT = 24'd362436;
    localparam t_frac C_CARRY_STEP = 24'd7654321;
    localparam t_frac C_CARRY_WRAP = 24'd16777213;

    // Iterations of the bit-serial remainder unit.
    localparam int DIV_STEPS = 32;

endpackage

[design/lfrg_in_if.sv]
// Request channel of the lagged Fibonacci generator: operation, seed and limit.
interface lfrg_in_if;
    import lfrg_pkg::*;

    logic  valid;
    logic  ready;
    t_op   operation;
    t_seed seed_value;
    t_word limit;

    modport source (output valid, operation, seed_value, limit, input ready);
    modport sink   (input valid, operation, seed_value, limit, output ready);
endinterface

[design/lfrg_out_if.sv]
// Result channel of the lagged Fibonacci generator: value and bad limit flag.
interface lfrg_out_if;
    import lfrg_pkg::*;

    logic  valid;
    logic  ready;
    t_word value;
    logic  bad_limit;

    modport source (output valid, value, bad_limit, input ready);
    modport sink   (input valid, value, bad_limit, output ready);
endinterface

[design/lagged_fibonacci_random_generator.sv]
// Lagged Fibonacci (RANMAR) random generator top level with lag table memory.
//
// Usage: requests arrive on i_in (valid/ready, one transfer per request) and
// each request gives exactly one result transfer on o_out. Operation 0
// reseeds, operation 1 returns a 24-bit fraction, operation 2 returns a
// packed 32-bit word reduced modulo limit (bad_limit set when limit is zero).
// The lag table sits in a single-port-read synchronous memory; every draw
// reads the long and short lag entries one after the other and writes the
// difference back, over the states ST_DRAW_A, ST_DRAW_B and ST_DRAW_C.
// Operation 1 makes one draw; operation 2 makes two draws, each followed by
// a rounding shift loop, then runs the bit-serial remainder unit and collects
// its result (skipped with a zero limit); operation 0 runs two seed
// remainders and then generates the lag table one bit at a time.
// After reset the block seeds itself with 1802/9373 while i_in.ready is low.
// A finished result waits in an output register; while the receiver stalls
// the block accepts and computes one more request, then holds it until the
// output register frees.
`include "lagged_fibonacci_random_generator_macros.svh"

module lagged_fibonacci_random_generator #(
    parameter int LONG_LAG  = 97,
    parameter int SHORT_LAG = 33
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lfrg_in_if.sink    i_in,
    lfrg_out_if.source o_out
);
    import lfrg_pkg::*;

    // Lag index width (1-based, holds LONG_LAG) and memory address width.
    localparam int IW = $clog2(LONG_LAG + 1);
    localparam int AW = $clog2(LONG_LAG);
    localparam int BW = $clog2(FRAC_W);
    localparam int CW = $clog2(DIV_STEPS);

    // Sequencer states.
    localparam logic [3:0] ST_BOOT      = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_MOD_HI    = 4'd2;
    localparam logic [3:0] ST_MOD_LO    = 4'd3;
    localparam logic [3:0] ST_SEED_INIT = 4'd4;
    localparam logic [3:0] ST_SEED_BIT  = 4'd5;
    localparam logic [3:0] ST_DRAW_A    = 4'd6;
    localparam logic [3:0] ST_DRAW_B    = 4'd7;
    localparam logic [3:0] ST_DRAW_C    = 4'd8;
    localparam logic [3:0] ST_SCALE     = 4'd9;
    localparam logic [3:0] ST_ROUND     = 4'd10;
    localparam logic [3:0] ST_MOD_OUT   = 4'd11;
    localparam logic [3:0] ST_DONE      = 4'd12;

    // Phases of one seeding bit.
    localparam logic [2:0] PH_MUL_IJ = 3'd0;
    localparam logic [2:0] PH_RED_IJ = 3'd1;
    localparam logic [2:0] PH_MUL_K  = 3'd2;
    localparam logic [2:0] PH_RED_K  = 3'd3;
    localparam logic [2:0] PH_BIT    = 3'd4;

    // Small restoring division by a constant: quotient and remainder, 8 steps.
    function automatic logic [15:0] div_small(input logic [14:0] x, input logic [7:0] d);
        logic [15:0] r;
        logic [15:0] sd;
        logic [7:0]  q;
        r = {1'b0, x};
        q = '0;
        for (int b = 7; b >= 0; b--) begin
            sd = {8'd0, d} << b;
            if (r >= sd) begin
                r    = r - sd;
                q[b] = 1'b1;
            end
        end
        return {q, r[7:0]};
    endfunction

    // Control and captured request.
    logic [3:0]  r_state;
    logic        r_seed_reply;
    logic        r_second;
    t_op         r_op;
    t_word       r_seed_lo;
    t_word       r_limit;
    logic [14:0] r_ij;
    logic [14:0] r_kl;

    // Generator state outside the memory.
    logic [IW-1:0] r_long_idx;
    logic [IW-1:0] r_short_idx;
    t_frac         r_carry;

    // Seeding recurrence registers.
    logic [7:0]        r_si;
    logic [7:0]        r_sj;
    logic [7:0]        r_sk;
    logic [7:0]        r_sl;
    logic [15:0]       r_prod;
    logic [7:0]        r_red;
    logic [2:0]        r_phase;
    logic [BW-1:0]     r_bit;
    logic [AW-1:0]     r_entry;
    logic [FRAC_W-2:0] r_acc;

    // Draw and scaling registers.
    t_frac       r_lval;
    t_frac       r_rd_data;
    logic [39:0] r_sc_p;
    logic [39:0] r_sc_t;
    logic [16:0] r_sc_u;
    logic [15:0] r_sc_mk;
    logic        r_sc_g;
    logic        r_sc_st;
    logic [15:0] r_word_hi;

    // Result staging and output register.
    t_word r_res_value;
    logic  r_res_bad;
    logic  r_out_valid;
    t_word r_out_value;
    logic  r_out_bad;

    // Bit-serial remainder unit.
    logic          r_div_busy;
    logic [CW-1:0] r_div_cnt;
    t_word         r_div_num;
    t_word         r_div_den;
    t_word         r_div_rem;

    // Lag table.
    t_frac r_lag_mem [LONG_LAG];

    logic          in_xfer;
    logic          out_load;
    logic [AW-1:0] long_addr;
    logic [AW-1:0] short_addr;
    logic [IW-1:0] long_idx_dec;
    logic [IW-1:0] short_idx_dec;
    t_frac         draw_uni;
    t_frac         carry_next;
    t_frac         draw_val;
    logic [39:0]   sc_p_init;
    logic          sc_up;
    logic [40:0]   sc_sum;
    logic [15:0]   sc_half;
    logic [15:0]   init_ij;
    logic [15:0]   init_kl;
    logic [14:0]   l_lin;
    logic [15:0]   l_div;
    logic [15:0]   m_div;
    logic [11:0]   seed_prod;
    logic          seed_bit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_frac         mem_wdata;
    logic          div_start;
    t_word         div_num;
    t_word         div_den;
    logic [32:0]   div_sh;
    t_word         div_rem_next;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out_value;
    assign o_out.bad_limit = r_out_bad;

    // Lag addresses and wrapped index steps.
    assign long_addr     = AW'(r_long_idx - IW'(1));
    assign short_addr    = AW'(r_short_idx - IW'(1));
    assign long_idx_dec  = (r_long_idx == IW'(1)) ? IW'(LONG_LAG) : r_long_idx - IW'(1);
    assign short_idx_dec = (r_short_idx == IW'(1)) ? IW'(LONG_LAG) : r_short_idx - IW'(1);

    // Draw arithmetic: table difference and draw mod 2^24, carry sequence mod C_CARRY_WRAP.
    assign draw_uni   = r_lval - r_rd_data;
    assign carry_next = (r_carry >= C_CARRY_STEP) ? r_carry - C_CARRY_STEP
                                                  : r_carry + (C_CARRY_WRAP - C_CARRY_STEP);
    assign draw_val   = draw_uni - carry_next;

    // The draw scaled by 65535, formed as a shifted subtraction.
    assign sc_p_init = {draw_val, 16'd0} - {16'd0, draw_val};

    // Round to nearest even at the ulp found by the shift loop.
    assign sc_up   = r_sc_g && (r_sc_st || r_sc_t[0]);
    assign sc_sum  = {1'b0, r_sc_p[39:16], r_sc_p[15:0] & ~r_sc_mk}
                   + {24'd0, (sc_up ? r_sc_u : 17'd0)};
    assign sc_half = sc_sum[39:24];

    // Seeding recurrence arithmetic.
    assign init_ij   = div_small(r_ij, C_IJ_DIV);
    assign init_kl   = div_small(r_kl, C_KL_DIV);
    assign l_lin     = {7'd0, r_sl} * {7'd0, C_L_MUL} + 15'd1;
    assign l_div     = div_small(l_lin, C_L_MOD);
    assign m_div     = div_small(r_prod[14:0], C_M_MOD);
    assign seed_prod = {6'd0, r_sl[5:0]} * {6'd0, r_sk[5:0]};
    assign seed_bit  = seed_prod[5];

    // Memory port selection: the long lag is read first, then the short lag.
    always_comb begin
        mem_raddr = (r_state == ST_DRAW_B) ? short_addr : long_addr;
        mem_we    = (r_state == ST_DRAW_C)
                 || ((r_state == ST_SEED_BIT) && (r_phase == PH_BIT)
                     && (r_bit == BW'(FRAC_W - 1)));
        mem_waddr = (r_state == ST_SEED_BIT) ? r_entry : long_addr;
        mem_wdata = (r_state == ST_SEED_BIT) ? {r_acc, seed_bit} : draw_uni;
    end

    // Lag table memory. Reads and writes of one draw are ordered by the
    // sequencer, so no read whose data is used overlaps a pending write to the same entry.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_lag_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_lag_mem[mem_raddr];
    end

    // Remainder unit start requests and operands.
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid && (i_in.operation == OP_SEED)) begin
                    div_start = 1'b1;
                    div_num   = i_in.seed_value[63:32];
                    div_den   = C_IJ_MOD;
                end
            end
            ST_MOD_HI: begin
                if (!r_div_busy) begin
                    div_start = 1'b1;
                    div_num   = r_seed_lo;
                    div_den   = C_KL_MOD;
                end
            end
            ST_ROUND: begin
                if (r_second && (r_limit != '0)) begin
                    div_start = 1'b1;
                    div_num   = {r_word_hi, sc_half};
                    div_den   = r_limit;
                end
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // One restoring remainder step per cycle.
    assign div_sh       = {r_div_rem, r_div_num[31]};
    assign div_rem_next = (div_sh >= {1'b0, r_div_den}) ? 32'(div_sh - {1'b0, r_div_den})
                                                         : div_sh[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
            r_div_num  <= div_num;
            r_div_den  <= div_den;
            r_div_rem  <= '0;
        end else if (r_div_busy) begin
            r_div_num <= {r_div_num[30:0], 1'b0};
            r_div_rem <= div_rem_next;
            r_div_cnt <= r_div_cnt + CW'(1);
            if (r_div_cnt == CW'(DIV_STEPS - 1)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BOOT;
        end else begin
            unique case (r_state)
                ST_BOOT: begin
                    r_ij         <= C_IJ_BOOT;
                    r_kl         <= C_KL_BOOT;
                    r_seed_reply <= 1'b0;
                    r_state      <= ST_SEED_INIT;
                end

                ST_IDLE: begin
                    if (in_xfer) begin
                        r_op      <= i_in.operation;
                        r_seed_lo <= i_in.seed_value[31:0];
                        r_limit   <= i_in.limit;
                        r_second  <= 1'b0;
                        unique case (i_in.operation)
                            OP_SEED: begin
                                r_seed_reply <= 1'b1;
                                r_state      <= ST_MOD_HI;
                            end
                            OP_FRAC, OP_BOUNDED: begin
                                r_state <= ST_DRAW_A;
                            end
                            default: begin
                                r_res_value <= '0;
                                r_res_bad   <= 1'b0;
                                r_state     <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_MOD_HI: begin
                    if (!r_div_busy) begin
                        r_ij    <= r_div_rem[14:0];
                        r_state <= ST_MOD_LO;
                    end
                end

                ST_MOD_LO: begin
                    if (!r_div_busy) begin
                        r_kl    <= r_div_rem[14:0];
                        r_state <= ST_SEED_INIT;
                    end
                end

                // Starting values of the recurrence from the two seeds.
                ST_SEED_INIT: begin
                    r_si    <= init_ij[15:8] + 8'd2;
                    r_sj    <= init_ij[7:0] + 8'd2;
                    r_sk    <= init_kl[15:8] + 8'd1;
                    r_sl    <= init_kl[7:0];
                    r_entry <= '0;
                    r_bit   <= '0;
                    r_phase <= PH_MUL_IJ;
                    r_state <= ST_SEED_BIT;
                end

                // One table bit per pass through the phases PH_MUL_IJ to PH_BIT, most significant first.
                ST_SEED_BIT: begin
                    unique case (r_phase)
                        PH_MUL_IJ: begin
                            r_prod  <= {8'd0, r_si} * {8'd0, r_sj};
                            r_sl    <= l_div[7:0];
                            r_phase <= PH_RED_IJ;
                        end
                        PH_RED_IJ: begin
                            r_red   <= m_div[7:0];
                            r_phase <= PH_MUL_K;
                        end
                        PH_MUL_K: begin
                            r_prod  <= {8'd0, r_red} * {8'd0, r_sk};
                            r_phase <= PH_RED_K;
                        end
                        PH_RED_K: begin
                            r_si    <= r_sj;
                            r_sj    <= r_sk;
                            r_sk    <= m_div[7:0];
                            r_phase <= PH_BIT;
                        end
                        PH_BIT: begin
                            r_acc   <= {r_acc[FRAC_W-3:0], seed_bit};
                            r_phase <= PH_MUL_IJ;
                            if (r_bit == BW'(FRAC_W - 1)) begin
                                r_bit <= '0;
                                if (r_entry == AW'(LONG_LAG - 1)) begin
                                    r_carry     <= C_CARRY_INIT;
                                    r_long_idx  <= IW'(LONG_LAG);
                                    r_short_idx <= IW'(SHORT_LAG);
                                    r_res_value <= '0;
                                    r_res_bad   <= 1'b0;
                                    r_state     <= r_seed_reply ? ST_DONE : ST_IDLE;
                                end else begin
                                    r_entry <= r_entry + AW'(1);
                                end
                            end else begin
                                r_bit <= r_bit + BW'(1);
                            end
                        end
                        default: begin
                            r_phase <= PH_MUL_IJ;
                        end
                    endcase
                end

                ST_DRAW_A: begin
                    r_state <= ST_DRAW_B;
                end

                ST_DRAW_B: begin
                    r_lval  <= r_rd_data;
                    r_state <= ST_DRAW_C;
                end

                // Write back the difference, step lags and carry; store a fraction or start scaling.
                ST_DRAW_C: begin
                    r_long_idx  <= long_idx_dec;
                    r_short_idx <= short_idx_dec;
                    r_carry     <= carry_next;
                    if (r_op == OP_FRAC) begin
                        r_res_value <= {8'd0, draw_val};
                        r_res_bad   <= 1'b0;
                        r_state     <= ST_DONE;
                    end else begin
                        r_sc_p  <= sc_p_init;
                        r_sc_t  <= sc_p_init;
                        r_sc_u  <= 17'd1;
                        r_sc_mk <= '0;
                        r_sc_g  <= 1'b0;
                        r_sc_st <= 1'b0;
                        r_state <= ST_SCALE;
                    end
                end

                // Shift until 24 significant bits remain, tracking guard and sticky.
                ST_SCALE: begin
                    if (r_sc_t[39:24] != '0) begin
                        r_sc_t  <= {1'b0, r_sc_t[39:1]};
                        r_sc_g  <= r_sc_t[0];
                        r_sc_st <= r_sc_st || r_sc_g;
                        r_sc_u  <= {r_sc_u[15:0], 1'b0};
                        r_sc_mk <= {r_sc_mk[14:0], 1'b1};
                    end else begin
                        r_state <= ST_ROUND;
                    end
                end

                ST_ROUND: begin
                    if (!r_second) begin
                        r_word_hi <= sc_half;
                        r_second  <= 1'b1;
                        r_state   <= ST_DRAW_A;
                    end else if (r_limit == '0) begin
                        r_res_value <= '0;
                        r_res_bad   <= 1'b1;
                        r_state     <= ST_DONE;
                    end else begin
                        r_state <= ST_MOD_OUT;
                    end
                end

                ST_MOD_OUT: begin
                    if (!r_div_busy) begin
                        r_res_value <= r_div_rem;
                        r_res_bad   <= 1'b0;
                        r_state     <= ST_DONE;
                    end
                end

                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
            r_out_value <= r_res_value;
            r_out_bad   <= r_res_bad;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The remainder unit is never running while a request can be taken.
    `LFRG_ASSERT_IMP(a_ready_div_free, i_clk, i_rst_n, i_in.ready, !r_div_busy, "divider busy while ready")
    // A new remainder is only started once the previous one is finished.
    `LFRG_ASSERT_IMP(a_div_start_free, i_clk, i_rst_n, div_start, !r_div_busy, "divider restarted while busy")
    // An accepted request always takes the sequencer out of idle.
    `LFRG_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_xfer, !i_in.ready, "ready held after a transfer")
    // Lag indices stay within the table between requests.
    `LFRG_ASSERT_IMP(a_idle_idx_range, i_clk, i_rst_n, (r_state == ST_IDLE), ((r_long_idx != '0) && (r_long_idx <= IW'(LONG_LAG)) && (r_short_idx != '0) && (r_short_idx <= IW'(LONG_LAG))), "lag index out of range")
    // The carry sequence stays below its wrap constant.
    `LFRG_ASSERT_IMP(a_idle_carry_range, i_clk, i_rst_n, (r_state == ST_IDLE), (r_carry < C_CARRY_WRAP), "carry out of range")

endmodule
